### hdl/edf_pkg.sv
// Shared constants and types of the EDF tick scheduler.
`default_nettype none
package edf_pkg;

   localparam int MAX_TASKS_DEF = 4;
   localparam int TASK_ID_W     = 3;
   localparam int LANE_W        = 16;
   localparam int CFG_W         = 64;
   localparam int TIME_W        = 32;
   localparam int DL_W          = 33;
   localparam int CNT_W         = 32;
   localparam int CSR_IDX_W     = 3;

   localparam logic [TASK_ID_W-1:0] IDLE_ID    = 3'd4;
   localparam logic [TASK_ID_W-1:0] TC_RESET   = 3'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXEC_TIMES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIODS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADLINES  = 3'd3;

   typedef struct packed {
      logic [TASK_ID_W-1:0] task_count;
      logic [CFG_W-1:0]     exec_times;
      logic [CFG_W-1:0]     periods;
      logic [CFG_W-1:0]     deadlines;
   } cfg_type;

   typedef struct packed {
      logic [TASK_ID_W-1:0] served_task;
      logic                 job_done;
      logic [CNT_W-1:0]     context_switches;
      logic [CNT_W-1:0]     preemptions;
      logic [TIME_W-1:0]    tick_time;
   } rsp_type;

endpackage
`default_nettype wire

### hdl/edf_req_if.sv
// Request channel interface of the EDF tick scheduler.
`default_nettype none
interface edf_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface
`default_nettype wire

### hdl/edf_rsp_if.sv
// Result channel interface of the EDF tick scheduler.
`default_nettype none
interface edf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [edf_pkg::TASK_ID_W-1:0]      served_task;
   logic                               job_done;
   logic [edf_pkg::CNT_W-1:0]          context_switches;
   logic [edf_pkg::CNT_W-1:0]          preemptions;
   logic [edf_pkg::TIME_W-1:0]         tick_time;

   modport source (output valid, output served_task, output job_done,
                   output context_switches, output preemptions, output tick_time,
                   input ready);
   modport sink (input valid, input served_task, input job_done,
                 input context_switches, input preemptions, input tick_time,
                 output ready);
endinterface
`default_nettype wire

### hdl/edf_tick_scheduler_unit.sv
// Top level of the EDF tick scheduler: registers, handshake and result register.
//
//  Channel   Direction  Transfer                    Payload
//  req_chan  in         valid && ready              restart
//  rsp_chan  out        valid && ready              served_task, job_done, counters, tick_time
//  csr_*     in         csr_we                      csr_index, csr_wdata
//
// A new request can be accepted every cycle unless a result waits and the sink holds ready low.
// The result appears in the result register in the cycle after its transfer in.
// The request side stalls only while a result waits and the sink holds ready low.
// The loop from the task state through the deadline pick and back sets the rate.
// Reset clears the task state and loads the register defaults; no clearing pass.
`default_nettype none
module edf_tick_scheduler_unit #(
   parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   edf_req_if.sink                              req_chan,
   edf_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [edf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [edf_pkg::CFG_W-1:0]       csr_wdata
);

   edf_pkg::cfg_type cfg_ff, cfg_in;
   edf_pkg::rsp_type rsp_ff, result;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_fire;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            edf_pkg::CSR_TASK_COUNT: cfg_in.task_count = csr_wdata[edf_pkg::TASK_ID_W-1:0];
            edf_pkg::CSR_EXEC_TIMES: cfg_in.exec_times = csr_wdata;
            edf_pkg::CSR_PERIODS:    cfg_in.periods    = csr_wdata;
            edf_pkg::CSR_DEADLINES:  cfg_in.deadlines  = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_valid_in   = req_fire || (rsp_valid_ff && !rsp_chan.ready);

   edf_core #(.MAX_TASKS(MAX_TASKS)) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (req_fire),
      .restart (req_chan.restart),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.task_count <= edf_pkg::TC_RESET;
         cfg_ff.exec_times <= '0;
         cfg_ff.periods    <= '0;
         cfg_ff.deadlines  <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.served_task      = rsp_ff.served_task;
   assign rsp_chan.job_done         = rsp_ff.job_done;
   assign rsp_chan.context_switches = rsp_ff.context_switches;
   assign rsp_chan.preemptions      = rsp_ff.preemptions;
   assign rsp_chan.tick_time        = rsp_ff.tick_time;

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_chan.valid)
      else $error("Accepted tick produced no result.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("Request accepted while a result is stalled.");

   a_restart_time: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.restart |=> rsp_chan.tick_time == '0)
      else $error("Restarted tick did not report time zero.");

   a_idle_not_done: assert property (@(posedge clock) disable iff (reset)
      req_fire && result.served_task == edf_pkg::IDLE_ID |=> !rsp_chan.job_done)
      else $error("Idle tick reported a finished job.");

endmodule
`default_nettype wire

### hdl/edf_pick.sv
// Earliest-deadline picker over the ready tasks, lowest index wins ties.
`default_nettype none
module edf_pick #(
   parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
   input  wire logic [MAX_TASKS-1:0]          ready_mask,
   input  wire logic [edf_pkg::DL_W-1:0]      deadline [MAX_TASKS],
   output      logic [edf_pkg::TASK_ID_W-1:0] pick
);

   logic [edf_pkg::DL_W-1:0] best_dl;

   always_comb begin
      pick    = edf_pkg::IDLE_ID;
      best_dl = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (ready_mask[i] && (pick == edf_pkg::IDLE_ID || deadline[i] < best_dl)) begin
            pick    = edf_pkg::TASK_ID_W'(i);
            best_dl = deadline[i];
         end
      end
   end

endmodule
`default_nettype wire

### hdl/edf_core.sv
// Task state and one-tick scheduling step of the EDF tick scheduler.
`default_nettype none
module edf_core #(
   parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic             restart,
   input  wire edf_pkg::cfg_type cfg,
   output      edf_pkg::rsp_type result
);

   localparam int LW = edf_pkg::LANE_W;
   localparam int TW = edf_pkg::TIME_W;
   localparam int DW = edf_pkg::DL_W;
   localparam int IW = edf_pkg::TASK_ID_W;
   localparam int CW = edf_pkg::CNT_W;

   logic [TW-1:0] timer_ff, timer_in;
   logic [LW-1:0] rem_ff [MAX_TASKS];
   logic [LW-1:0] rem_in [MAX_TASKS];
   logic [TW-1:0] rel_ff [MAX_TASKS];
   logic [TW-1:0] rel_in [MAX_TASKS];
   logic [DW-1:0] dl_ff [MAX_TASKS];
   logic [DW-1:0] dl_in [MAX_TASKS];
   logic [MAX_TASKS-1:0] rdy_ff, rdy_in;
   logic [IW-1:0] chosen_ff, chosen_in;
   logic [IW-1:0] last_ff, last_in;
   logic [LW-1:0] left_ff, left_in;
   logic [CW-1:0] sw_ff, sw_in;
   logic [CW-1:0] pre_ff, pre_in;

   logic [TW-1:0] e_timer;
   logic [LW-1:0] e_rem [MAX_TASKS];
   logic [TW-1:0] e_rel [MAX_TASKS];
   logic [DW-1:0] e_dl [MAX_TASKS];
   logic [MAX_TASKS-1:0] e_rdy;
   logic [IW-1:0] e_chosen, e_last;
   logic [LW-1:0] e_left;
   logic [CW-1:0] e_sw, e_pre;

   logic [IW-1:0] n_eff;
   logic [MAX_TASKS-1:0] inuse, rel_hit, rdy1, hit, mask1, mask2;
   logic [IW-1:0] pick1, pick2, chosen1;
   logic released, any_ready, idle, work, done;
   logic [LW-1:0] sel_rem, rem_dec;
   logic sw_inc, pre_inc;
   logic [LW-1:0] lane_exec [MAX_TASKS];
   logic [LW-1:0] lane_per [MAX_TASKS];
   logic [LW-1:0] lane_dl [MAX_TASKS];
   logic [TW-1:0] rel_next [MAX_TASKS];

   always_comb begin
      if (cfg.task_count == '0) begin
         n_eff = IW'(1);
      end else if (cfg.task_count > IW'(MAX_TASKS)) begin
         n_eff = IW'(MAX_TASKS);
      end else begin
         n_eff = cfg.task_count;
      end
   end

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_task
      assign lane_exec[i] = cfg.exec_times[LW*i +: LW];
      assign lane_per[i]  = cfg.periods[LW*i +: LW];
      assign lane_dl[i]   = cfg.deadlines[LW*i +: LW];

      assign e_rem[i] = restart ? lane_exec[i] : rem_ff[i];
      assign e_rel[i] = restart ? '0 : rel_ff[i];
      assign e_dl[i]  = restart ? DW'(lane_dl[i]) : dl_ff[i];
      assign e_rdy[i] = restart ? 1'b0 : rdy_ff[i];

      assign inuse[i]   = IW'(i) < n_eff;
      assign rel_hit[i] = inuse[i] && (e_rel[i] == e_timer);
      assign rdy1[i]    = e_rdy[i] | rel_hit[i];
      assign hit[i]     = !idle && (chosen1 == IW'(i));
      assign rel_next[i] = e_rel[i] + TW'(lane_per[i]);

      always_comb begin
         rem_in[i] = rem_ff[i];
         rel_in[i] = rel_ff[i];
         dl_in[i]  = dl_ff[i];
         rdy_in[i] = rdy_ff[i];
         if (step) begin
            rem_in[i] = e_rem[i];
            rel_in[i] = e_rel[i];
            dl_in[i]  = e_dl[i];
            rdy_in[i] = rdy1[i];
            if (hit[i] && done) begin
               rem_in[i] = lane_exec[i];
               rel_in[i] = rel_next[i];
               dl_in[i]  = DW'(rel_next[i]) + DW'(lane_dl[i]);
               rdy_in[i] = 1'b0;
            end else if (hit[i]) begin
               rem_in[i] = rem_dec;
            end
         end
      end
   end

   assign e_timer  = restart ? '0 : timer_ff;
   assign e_chosen = restart ? edf_pkg::IDLE_ID : chosen_ff;
   assign e_last   = restart ? edf_pkg::IDLE_ID : last_ff;
   assign e_left   = restart ? '0 : left_ff;
   assign e_sw     = restart ? '0 : sw_ff;
   assign e_pre    = restart ? '0 : pre_ff;

   assign mask1     = rdy1 & inuse;
   assign mask2     = mask1 & ~hit;
   assign released  = |rel_hit;
   assign any_ready = |mask1;

   edf_pick #(.MAX_TASKS(MAX_TASKS)) u_pick_tick (
      .ready_mask (mask1),
      .deadline   (e_dl),
      .pick       (pick1)
   );

   edf_pick #(.MAX_TASKS(MAX_TASKS)) u_pick_done (
      .ready_mask (mask2),
      .deadline   (e_dl),
      .pick       (pick2)
   );

   assign chosen1 = (released || !any_ready) ? pick1 : e_chosen;
   assign idle    = chosen1 >= n_eff;

   always_comb begin
      sel_rem = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (hit[i]) begin
            sel_rem = e_rem[i];
         end
      end
   end

   assign work    = !idle && (sel_rem != '0);
   assign rem_dec = work ? sel_rem - LW'(1) : sel_rem;
   assign done    = !idle && (rem_dec == '0);
   assign sw_inc  = idle || (work && (chosen1 != e_last));
   assign pre_inc = work && (chosen1 != e_last) && (e_last != edf_pkg::IDLE_ID)
                    && (e_left != '0);

   always_comb begin
      timer_in  = timer_ff;
      chosen_in = chosen_ff;
      last_in   = last_ff;
      left_in   = left_ff;
      sw_in     = sw_ff;
      pre_in    = pre_ff;
      if (step) begin
         timer_in  = e_timer + TW'(1);
         chosen_in = done ? pick2 : chosen1;
         last_in   = work ? chosen1 : e_last;
         left_in   = work ? rem_dec : e_left;
         sw_in     = (sw_inc && e_sw != '1) ? e_sw + CW'(1) : e_sw;
         pre_in    = (pre_inc && e_pre != '1) ? e_pre + CW'(1) : e_pre;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff  <= '0;
         rdy_ff    <= '0;
         chosen_ff <= edf_pkg::IDLE_ID;
         last_ff   <= edf_pkg::IDLE_ID;
         left_ff   <= '0;
         sw_ff     <= '0;
         pre_ff    <= '0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            rem_ff[i] <= '0;
            rel_ff[i] <= '0;
            dl_ff[i]  <= '0;
         end
      end else begin
         timer_ff  <= timer_in;
         rdy_ff    <= rdy_in;
         chosen_ff <= chosen_in;
         last_ff   <= last_in;
         left_ff   <= left_in;
         sw_ff     <= sw_in;
         pre_ff    <= pre_in;
         for (int i = 0; i < MAX_TASKS; i++) begin
            rem_ff[i] <= rem_in[i];
            rel_ff[i] <= rel_in[i];
            dl_ff[i]  <= dl_in[i];
         end
      end
   end

   assign result.served_task      = idle ? edf_pkg::IDLE_ID : chosen1;
   assign result.job_done         = done;
   assign result.context_switches = sw_in;
   assign result.preemptions      = pre_in;
   assign result.tick_time        = e_timer;

endmodule
`default_nettype wire
